### rtl/core/qte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, constants and cell handoff types for the quaternion to
// Euler angle converter.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int CordicStepsDef = 20;

  localparam int QW      = 32;   // quaternion component width
  localparam int PW      = 34;   // floored Q.30 product width
  localparam int AW      = 36;   // atan2 operand width
  localparam int SW      = 32;   // saturated sine width
  localparam int VW      = 62;   // integer square root working width
  localparam int SqrtSteps = 31; // one cell per result bit of sqrt(2^60)
  localparam int CW      = 40;   // CORDIC x/y width, covers gain growth
  localparam int ZW      = 34;   // CORDIC angle width, Q.30 radians
  localparam int MW      = 48;   // angle times tenths-per-radian width

  localparam logic signed [AW-1:0] Q30_ONE      = AW'(64'sd1073741824);
  localparam logic signed [ZW-1:0] HALF_PI_Q30  = ZW'(64'sd1686629713);
  localparam logic signed [MW-1:0] TENTHS_PER_RAD = MW'(64'sd573);
  localparam logic signed [MW-1:0] HALF_TURN_Q30  = MW'(64'sd1800) <<< 30;
  localparam logic [VW-1:0]        ONE_Q60        = VW'(1) << 60;

  localparam logic [2:0] ADDR_FLIP_ROLL = 3'd0;

  typedef struct packed {
    logic [VW-1:0] v;
    logic [VW-1:0] res;
  } sq_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cvec_t;

  typedef struct packed {
    logic signed [SW-1:0] s;
    logic signed [AW-1:0] rn;
    logic signed [AW-1:0] rd;
    logic signed [AW-1:0] yn;
    logic signed [AW-1:0] yd;
  } pend_t;

  // atan(2^-i) in Q.30 radians, truncated
  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = ZW'(64'sd843314856);
      1:  r = ZW'(64'sd497837829);
      2:  r = ZW'(64'sd263043836);
      3:  r = ZW'(64'sd133525158);
      4:  r = ZW'(64'sd67021686);
      5:  r = ZW'(64'sd33543515);
      6:  r = ZW'(64'sd16775850);
      7:  r = ZW'(64'sd8388437);
      8:  r = ZW'(64'sd4194282);
      9:  r = ZW'(64'sd2097149);
      10: r = ZW'(64'sd1048575);
      11: r = ZW'(64'sd524287);
      12: r = ZW'(64'sd262143);
      13: r = ZW'(64'sd131071);
      14: r = ZW'(64'sd65535);
      15: r = ZW'(64'sd32767);
      16: r = ZW'(64'sd16383);
      17: r = ZW'(64'sd8191);
      18: r = ZW'(64'sd4095);
      19: r = ZW'(64'sd2047);
      20: r = ZW'(64'sd1023);
      21: r = ZW'(64'sd511);
      22: r = ZW'(64'sd255);
      23: r = ZW'(64'sd127);
      24: r = ZW'(64'sd63);
      25: r = ZW'(64'sd31);
      26: r = ZW'(64'sd15);
      27: r = ZW'(64'sd8);
      28: r = ZW'(64'sd4);
      29: r = ZW'(64'sd2);
      30: r = ZW'(64'sd1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // divide by 2^30, rounding toward zero
  function automatic logic signed [MW-1:0] trunc_q30(input logic signed [MW-1:0] a);
    logic signed [MW-1:0] b;
    b = a + (a[MW-1] ? MW'(64'sd1073741823) : '0);
    return b >>> 30;
  endfunction

endpackage

### rtl/core/qte_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_sqrt_cell
// One bit step of the restoring integer square root.
// ----------------------------------------------------------------------------
module qte_sqrt_cell import qte_pkg::*; #(
  parameter int BitPos = 60
) (
  input  logic clk_i,
  input  logic en_i,
  input  sq_t  d_i,
  output sq_t  d_o
);

  localparam logic [VW-1:0] Bit = VW'(1) << BitPos;

  sq_t         d_d;
  sq_t         d_q;
  logic [VW-1:0] trial;

  always_comb begin
    trial = d_i.res + Bit;
    if (d_i.v >= trial) begin
      d_d.v   = d_i.v - trial;
      d_d.res = (d_i.res >> 1) + Bit;
    end else begin
      d_d.v   = d_i.v;
      d_d.res = d_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;

endmodule

### rtl/core/qte_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_cordic_cell
// One vectoring micro-rotation; drives y toward zero and books the angle.
// ----------------------------------------------------------------------------
module qte_cordic_cell import qte_pkg::*; #(
  parameter int Idx = 0
) (
  input  logic  clk_i,
  input  logic  en_i,
  input  cvec_t d_i,
  output cvec_t d_o
);

  cvec_t                d_d;
  cvec_t                d_q;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;

  always_comb begin
    dx = d_i.y >>> Idx;
    dy = d_i.x >>> Idx;
    d_d.zero = d_i.zero;
    // y of zero rotates as positive
    if (!d_i.y[CW-1]) begin
      d_d.x = d_i.x + dx;
      d_d.y = d_i.y - dy;
      d_d.z = d_i.z + atan_q30(Idx);
    end else begin
      d_d.x = d_i.x - dx;
      d_d.y = d_i.y + dy;
      d_d.z = d_i.z - atan_q30(Idx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;

endmodule

### rtl/core/quaternion_to_euler_angles.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Z-Y-X Euler angles (pitch, roll, yaw) in tenths of a degree from a Q2.30
// attitude quaternion.
// ----------------------------------------------------------------------------
// The block takes one item per clock, except while the pipeline holds, and
// returns one result per item whose has_quat flag (tuser) is set; items
// without a quaternion are dropped. The pipeline is fully streamed through
// the input register, products, sums, square, 31 square root cells, quadrant
// pre-rotation, CORDIC_STEPS rotation cells, scaling and output register.
// The whole pipeline holds as one while a result waits at the output and
// m_axis_tready is low; otherwise it advances every cycle. Pitch comes from
// atan2(s, sqrt(1 - s^2)) with s saturated to +/-1, roll and yaw from atan2,
// each through its own row of CORDIC cells. Angles are scaled by 573 tenths
// per radian and truncated toward zero. Register flip_roll (address 0)
// shifts roll by half a turn toward the opposite sign; write it only while
// the block is idle.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles import qte_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // stream in
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // quat_w, quat_x, quat_y, quat_z
  input  logic [0:0]   s_axis_tuser,  // has_quat
  // stream out
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [39:0]  m_axis_tdata,  // pitch_tenths, roll_tenths, yaw_tenths
  // register port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int NCh = 3;  // pitch, roll, yaw

  logic en;

  // --------------------------------------------------------------------------
  // Register port
  // --------------------------------------------------------------------------
  logic flip_roll_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flip_roll_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr == ADDR_FLIP_ROLL) begin
      flip_roll_q <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_FLIP_ROLL) ? {31'b0, flip_roll_q} : '0;

  // --------------------------------------------------------------------------
  // Input register; drop items without a quaternion
  // --------------------------------------------------------------------------
  logic                 vld0_q;
  logic signed [QW-1:0] w0_q, x0_q, y0_q, z0_q;

  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (en) begin
      vld0_q <= s_axis_tvalid && s_axis_tuser[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w0_q <= s_axis_tdata[31:0];
      x0_q <= s_axis_tdata[63:32];
      y0_q <= s_axis_tdata[95:64];
      z0_q <= s_axis_tdata[127:96];
    end
  end

  // --------------------------------------------------------------------------
  // Products, each floored to Q.30
  // --------------------------------------------------------------------------
  function automatic logic signed [PW-1:0] mulq(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    logic signed [2*QW-1:0] p;
    logic signed [2*QW-1:0] f;
    p = a * b;
    f = p >>> 30;
    return f[PW-1:0];
  endfunction

  logic                 vld1_q;
  logic signed [PW-1:0] wy_q, xz_q, yz_q, wx_q, xy_q, wz_q, ww_q, xx_q, yy_q, zz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (en) begin
      vld1_q <= vld0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wy_q <= mulq(w0_q, y0_q);
      xz_q <= mulq(x0_q, z0_q);
      yz_q <= mulq(y0_q, z0_q);
      wx_q <= mulq(w0_q, x0_q);
      xy_q <= mulq(x0_q, y0_q);
      wz_q <= mulq(w0_q, z0_q);
      ww_q <= mulq(w0_q, w0_q);
      xx_q <= mulq(x0_q, x0_q);
      yy_q <= mulq(y0_q, y0_q);
      zz_q <= mulq(z0_q, z0_q);
    end
  end

  // --------------------------------------------------------------------------
  // Sums; saturate the sine to +/-1
  // --------------------------------------------------------------------------
  logic                 vld2_q;
  pend_t                p2_d, p2_q;
  logic signed [AW-1:0] s_raw;

  always_comb begin
    s_raw   = (AW'(wy_q) - AW'(xz_q)) <<< 1;
    if (s_raw > Q30_ONE) begin
      p2_d.s = SW'(Q30_ONE);
    end else if (s_raw < -Q30_ONE) begin
      p2_d.s = SW'(-Q30_ONE);
    end else begin
      p2_d.s = SW'(s_raw);
    end
    p2_d.rn = (AW'(yz_q) + AW'(wx_q)) <<< 1;
    p2_d.rd = Q30_ONE - ((AW'(xx_q) + AW'(yy_q)) <<< 1);
    p2_d.yn = (AW'(xy_q) + AW'(wz_q)) <<< 1;
    p2_d.yd = AW'(ww_q) + AW'(xx_q) - AW'(yy_q) - AW'(zz_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else if (en) begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_q <= p2_d;
    end
  end

  // --------------------------------------------------------------------------
  // Square of the sine
  // --------------------------------------------------------------------------
  logic                   vld3_q;
  pend_t                  p3_q;
  logic signed [2*SW-1:0] sq_full;
  logic [VW-1:0]          sq3_q;

  assign sq_full = p2_q.s * p2_q.s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
    end else if (en) begin
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_q  <= p2_q;
      sq3_q <= VW'(sq_full);
    end
  end

  // --------------------------------------------------------------------------
  // Cosine: integer square root of 2^60 - s^2, one result bit per cell.
  // Hold the other operands in a matching delay line.
  // --------------------------------------------------------------------------
  sq_t   sq_chain [SqrtSteps+1];
  pend_t pend_q   [SqrtSteps];
  logic  vsq_q    [SqrtSteps];

  assign sq_chain[0].v   = ONE_Q60 - sq3_q;
  assign sq_chain[0].res = '0;

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    qte_sqrt_cell #(
      .BitPos (60 - 2 * k)
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (sq_chain[k]),
      .d_o   (sq_chain[k+1])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vsq_q[k] <= 1'b0;
      end else if (en) begin
        vsq_q[k] <= (k == 0) ? vld3_q : vsq_q[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        pend_q[k] <= (k == 0) ? p3_q : pend_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Quadrant pre-rotation: fold x < 0 into the right half plane by +/-pi/2,
  // flag the zero vector.
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] ax [NCh];
  logic signed [CW-1:0] ay [NCh];
  cvec_t                pre_d [NCh];
  cvec_t                cv    [NCh][CORDIC_STEPS+1];
  logic                 vp_q;

  assign ay[0] = CW'(pend_q[SqrtSteps-1].s);
  assign ax[0] = CW'(sq_chain[SqrtSteps].res);
  assign ay[1] = CW'(pend_q[SqrtSteps-1].rn);
  assign ax[1] = CW'(pend_q[SqrtSteps-1].rd);
  assign ay[2] = CW'(pend_q[SqrtSteps-1].yn);
  assign ax[2] = CW'(pend_q[SqrtSteps-1].yd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (en) begin
      vp_q <= vsq_q[SqrtSteps-1];
    end
  end

  for (genvar c = 0; c < NCh; c++) begin : g_ch
    always_comb begin
      pre_d[c].zero = (ax[c] == '0) && (ay[c] == '0);
      if (ax[c][CW-1]) begin
        if (!ay[c][CW-1]) begin
          pre_d[c].x = ay[c];
          pre_d[c].y = -ax[c];
          pre_d[c].z = HALF_PI_Q30;
        end else begin
          pre_d[c].x = -ay[c];
          pre_d[c].y = ax[c];
          pre_d[c].z = -HALF_PI_Q30;
        end
      end else begin
        pre_d[c].x = ax[c];
        pre_d[c].y = ay[c];
        pre_d[c].z = '0;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        cv[c][0] <= pre_d[c];
      end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
      qte_cordic_cell #(
        .Idx (k)
      ) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .d_i   (cv[c][k]),
        .d_o   (cv[c][k+1])
      );
    end
  end

  logic vc_q [CORDIC_STEPS];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vc
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vc_q[k] <= 1'b0;
      end else if (en) begin
        vc_q[k] <= (k == 0) ? vp_q : vc_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Scale to tenths of a degree; atan2 of the zero vector is zero
  // --------------------------------------------------------------------------
  logic                 vm_q;
  logic signed [MW-1:0] ang_m_q [NCh];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (en) begin
      vm_q <= vc_q[CORDIC_STEPS-1];
    end
  end

  for (genvar c = 0; c < NCh; c++) begin : g_scale
    always_ff @(posedge clk_i) begin
      if (en) begin
        ang_m_q[c] <= cv[c][CORDIC_STEPS].zero ? '0 :
                      MW'(cv[c][CORDIC_STEPS].z) * TENTHS_PER_RAD;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Flipped-mounting shift of roll, truncation, output register
  // --------------------------------------------------------------------------
  logic                 out_vld_q;
  logic signed [MW-1:0] roll_shift;
  logic signed [MW-1:0] pitch_t, roll_t, yaw_t;
  logic [10:0]          pitch_q;
  logic [11:0]          roll_q, yaw_q;

  assign en = !out_vld_q || m_axis_tready;

  always_comb begin
    roll_shift = ang_m_q[1];
    if (flip_roll_q) begin
      // a roll of exactly zero counts as non-negative
      roll_shift = ang_m_q[1][MW-1] ? ang_m_q[1] + HALF_TURN_Q30
                                    : ang_m_q[1] - HALF_TURN_Q30;
    end
    pitch_t = trunc_q30(ang_m_q[0]);
    roll_t  = trunc_q30(roll_shift);
    yaw_t   = trunc_q30(ang_m_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pitch_q <= pitch_t[10:0];
      roll_q  <= roll_t[11:0];
      yaw_q   <= yaw_t[11:0];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b0, yaw_q, roll_q, pitch_q};

endmodule
